// File: design/mrcs_pkg.sv
// Shared types, constants and constant tables for the response curve shaper.
// No dependencies; every other design file imports this package.
package mrcs_pkg;

  // Q1.16 value width and the fixed-point one
  localparam int VAL_W = 17;
  localparam logic [VAL_W-1:0] ONE = 17'h10000;
  localparam logic [VAL_W-1:0] HALF_LSB = 17'h08000;

  // Curve table and exponential table geometry
  localparam int CURVE_POINTS = 64;
  localparam int CP_IDX_W = $clog2(CURVE_POINTS);
  localparam int EXP_POINTS = 256;
  localparam int EXP_IDX_W = $clog2(EXP_POINTS);
  localparam int MAX_STEPS = 128;
  localparam int STEP_W = 8;

  // Window floor when an exponential curve is in use, and divisor floor
  localparam logic [VAL_W-1:0] EXP_WIN_MIN = 17'd7;
  localparam logic [VAL_W-1:0] DEN_MIN = 17'd66;

  // Phase offsets
  localparam logic [15:0] PH_90 = 16'h4000;
  localparam logic [15:0] PH_180 = 16'h8000;
  localparam logic [15:0] PH_270 = 16'hC000;

  // Divider: one quotient bit per stage
  localparam int DIV_STAGES = 16;
  localparam int DIV_LAT = DIV_STAGES + 1;

  // Curve evaluation depth and full back-end latency
  localparam int CURVE_LAT = 6;
  localparam int QNT_AT = DIV_LAT + 1;
  localparam int POS_AT = QNT_AT + DIV_LAT;
  localparam int TAB_WR_AT = POS_AT + 2;
  localparam int CURVE_AT = POS_AT + CURVE_LAT;
  localparam int BACK_LAT = CURVE_AT + 4;

  // Queue depths
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  // Log2(10000) in Q32 and the square-root chain length for the exp table
  localparam logic [63:0] LOG2_10000_Q32 = 64'd57070290109;
  localparam int ROOT_BITS = 24;

  typedef enum logic [3:0] {
    CRV_LINEAR  = 4'd0,
    CRV_EXP     = 4'd1,
    CRV_EXP_MIR = 4'd2,
    CRV_POW5    = 4'd3,
    CRV_POW4    = 4'd4,
    CRV_POW3    = 4'd5,
    CRV_POW2    = 4'd6,
    CRV_MPOW2   = 4'd7,
    CRV_MPOW3   = 4'd8,
    CRV_MPOW4   = 4'd9,
    CRV_MPOW5   = 4'd10,
    CRV_PH90    = 4'd11,
    CRV_PH180   = 4'd12,
    CRV_PH270   = 4'd13,
    CRV_TAB1    = 4'd14,
    CRV_TAB2    = 4'd15
  } curve_e;

  typedef enum logic [2:0] {
    REG_CURVE_A  = 3'd0,
    REG_CURVE_B  = 3'd1,
    REG_MORPH    = 3'd2,
    REG_WIN_LO   = 3'd3,
    REG_WIN_HI   = 3'd4,
    REG_RNG_LO   = 3'd5,
    REG_RNG_HI   = 3'd6,
    REG_STEPS    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    curve_e            a_type;
    curve_e            b_type;
    logic [VAL_W-1:0]  morph;
    logic [VAL_W-1:0]  win_lo;
    logic [VAL_W-1:0]  win_hi;
    logic [VAL_W-1:0]  rng_lo;
    logic [VAL_W-1:0]  rng_hi;
    logic [STEP_W-1:0] steps;
  } cfg_t;

  // One classified word between front and back
  typedef struct packed {
    logic                wr;
    logic                sel;
    logic [CP_IDX_W-1:0] idx;
    logic [VAL_W-1:0]    val;
    logic [VAL_W-1:0]    num;
    logic [VAL_W-1:0]    den;
  } mid_item_t;

  // Curve table write control
  typedef struct packed {
    logic                en;
    logic                sel;
    logic [CP_IDX_W-1:0] idx;
    logic [VAL_W-1:0]    val;
  } tab_wr_t;

  typedef logic [VAL_W-1:0] exp_rom_t [EXP_POINTS];
  typedef logic [VAL_W-1:0] ramp_t [CURVE_POINTS];

  function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Rounded Q1.16 product
  function automatic logic [VAL_W-1:0] qmul(input logic [VAL_W-1:0] a,
                                           input logic [VAL_W-1:0] b);
    logic [2*VAL_W-1:0] p;
    p = (2*VAL_W)'(a) * (2*VAL_W)'(b) + (2*VAL_W)'(HALF_LSB);
    return p[VAL_W+15:16];
  endfunction

  // Rounded sum of two interpolation products
  function automatic logic [VAL_W-1:0] rsum(input logic [2*VAL_W-1:0] a,
                                           input logic [2*VAL_W-1:0] b);
    logic [2*VAL_W:0] s;
    s = (2*VAL_W+1)'(a) + (2*VAL_W+1)'(b) + (2*VAL_W+1)'(HALF_LSB);
    return s[VAL_W+15:16];
  endfunction

  // Curves evaluated on the mirrored position
  function automatic logic is_mirror(input curve_e t);
    return (t == CRV_EXP_MIR) || (t == CRV_MPOW2) || (t == CRV_MPOW3) ||
           (t == CRV_MPOW4) || (t == CRV_MPOW5);
  endfunction

  // Power order of a power curve, one otherwise
  function automatic logic [2:0] pow_order(input curve_e t);
    case (t)
      CRV_POW5, CRV_MPOW5: return 3'd5;
      CRV_POW4, CRV_MPOW4: return 3'd4;
      CRV_POW3, CRV_MPOW3: return 3'd3;
      CRV_POW2, CRV_MPOW2: return 3'd2;
      default:             return 3'd1;
    endcase
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Exponential table: 65536 * 10000^(i/(N-1) - 1) for N points, rounded, built at elaboration
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] roots [ROOT_BITS+1];
    logic [63:0] e;
    logic [63:0] acc;
    logic [63:0] fin;
    int          ip;
    logic [31:0] fr;
    roots[0] = 64'd1 << 29;
    for (int k = 1; k <= ROOT_BITS; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < EXP_POINTS; i++) begin
      e = 64'(EXP_POINTS - 1 - i) * LOG2_10000_Q32 / 64'(EXP_POINTS - 1);
      ip = int'(e[63:32]);
      fr = e[31:0];
      acc = 64'd1 << 30;
      for (int k = 1; k <= ROOT_BITS; k++) begin
        if (fr[32-k]) acc = (acc * roots[k] + (64'd1 << 29)) >> 30;
      end
      fin = (acc * 64'd65536 + (64'd1 << (29 + ip))) >> (30 + ip);
      rom[i] = fin[VAL_W-1:0];
    end
    return rom;
  endfunction

  // Reset contents of the curve tables: floor(i * 65536 / (points - 1))
  function automatic ramp_t build_ramp();
    ramp_t       r;
    logic [63:0] v;
    for (int i = 0; i < CURVE_POINTS; i++) begin
      v = 64'(i) * 64'd65536 / 64'(CURVE_POINTS - 1);
      r[i] = v[VAL_W-1:0];
    end
    return r;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();
  localparam ramp_t RAMP = build_ramp();

endpackage

// File: design/mrcs_front.sv
// Front end: classifies incoming words, computes the window numerator and
// divisor, and holds them in a short queue for the back end. Uses mrcs_pkg.
module mrcs_front import mrcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                push,
  output logic                full,
  input  logic                req_type,
  input  logic [VAL_W-1:0]    sample_value,
  input  logic                table_select,
  input  logic [CP_IDX_W-1:0] table_index,
  input  logic [VAL_W-1:0]    table_value,
  input  logic                mid_pop,
  output mid_item_t           mid_head,
  output logic                mid_empty
);

  logic [VAL_W-1:0] lo, hi, x, num, den;
  logic             exp_used;
  mid_item_t        item;
  mid_item_t        q_mem [MID_DEPTH];
  logic [MID_PTR_W-1:0] wptr, rptr;
  logic [MID_PTR_W:0]   count;
  logic             do_push;

  // Clamp to the window and form numerator and divisor
  always_comb begin
    exp_used = (cfg.a_type == CRV_EXP) || (cfg.a_type == CRV_EXP_MIR) ||
               (cfg.b_type == CRV_EXP) || (cfg.b_type == CRV_EXP_MIR);
    lo = sat_one(cfg.win_lo);
    hi = sat_one(cfg.win_hi);
    if (exp_used) begin
      if (lo < EXP_WIN_MIN) lo = EXP_WIN_MIN;
      if (hi < EXP_WIN_MIN) hi = EXP_WIN_MIN;
    end
    x = (sample_value < lo) ? lo : sample_value;
    if (x > hi) x = hi;
    num = (x > lo) ? x - lo : '0;
    den = (hi > lo) ? hi - lo : '0;
    if (den < DEN_MIN) den = DEN_MIN;
    item.wr  = req_type;
    item.sel = table_select;
    item.idx = table_index;
    item.val = sat_one(table_value);
    item.num = num;
    item.den = den;
  end

  assign full      = (count == (MID_PTR_W+1)'(MID_DEPTH));
  assign mid_empty = (count == '0);
  assign do_push   = push && !full;
  assign mid_head  = q_mem[rptr];

  // Store the classified word
  always_ff @(posedge clk) begin
    if (do_push) q_mem[wptr] <= item;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (mid_pop) rptr <= rptr + 1'b1;
      count <= count + (MID_PTR_W+1)'(do_push) - (MID_PTR_W+1)'(mid_pop);
    end
  end

endmodule

// File: design/mrcs_div.sv
// Pipelined restoring divider: floor(num * 65536 / den), or one when
// num is at least den. One quotient bit per stage. Uses mrcs_pkg.
module mrcs_div import mrcs_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [VAL_W-1:0] num,
  input  logic [VAL_W-1:0] den,
  output logic [VAL_W-1:0] quo
);

  logic [15:0]           drem [DIV_STAGES+1];
  logic [VAL_W-1:0]      dden [DIV_STAGES+1];
  logic [DIV_STAGES-1:0] dq   [DIV_STAGES+1];
  logic                  dsat [DIV_STAGES+1];

  // Load: saturate when the ratio reaches one
  always_ff @(posedge clk) begin
    if (en) begin
      dsat[0] <= (num >= den);
      drem[0] <= (num >= den) ? '0 : num[15:0];
      dden[0] <= den;
      dq[0]   <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [VAL_W-1:0] trial;
    logic             ge;
    logic [VAL_W-1:0] diff;
    assign trial = {drem[k], 1'b0};
    assign ge    = (trial >= dden[k]);
    assign diff  = ge ? trial - dden[k] : trial;

    // Shift in one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        drem[k+1] <= diff[15:0];
        dden[k+1] <= dden[k];
        dq[k+1]   <= {dq[k][DIV_STAGES-2:0], ge};
        dsat[k+1] <= dsat[k];
      end
    end
  end

  assign quo = dsat[DIV_STAGES] ? ONE : {1'b0, dq[DIV_STAGES]};

endmodule

// File: design/mrcs_curves.sv
// Curve evaluation: power chains, exponential lookup, phase shifts and the
// two loadable curve tables, for both selected curves. Uses mrcs_pkg.
module mrcs_curves import mrcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  curve_e           a_type,
  input  curve_e           b_type,
  input  logic [VAL_W-1:0] pos,
  input  tab_wr_t          tab_wr,
  output logic [VAL_W-1:0] curve_a,
  output logic [VAL_W-1:0] curve_b
);

  localparam int EA_W = VAL_W + EXP_IDX_W;
  localparam int TA_W = VAL_W + CP_IDX_W;

  curve_e            ty [2];
  logic [VAL_W-1:0]  p1, p2, p3, p4, p5;
  logic [VAL_W-1:0]  u1 [2], u2 [2], u3 [2], u4 [2];
  logic [VAL_W-1:0]  r2 [2], r3 [2], r4 [2], r5 [2];
  logic [EA_W-1:0]   ea [2];
  logic [EXP_IDX_W-1:0] ei0 [2], ei1 [2];
  logic [15:0]       ef2 [2], ef3 [2];
  logic [VAL_W-1:0]  et0 [2], et1 [2];
  logic [2*VAL_W-1:0] ep0 [2], ep1 [2];
  logic [VAL_W-1:0]  esum [2];
  logic [TA_W-1:0]   ta;
  logic [CP_IDX_W-1:0] ti0, ti1;
  logic [15:0]       tf2, tf3;
  logic [VAL_W-1:0]  tab_mem [2][CURVE_POINTS];
  logic              tab_vld [2][CURVE_POINTS];
  logic [VAL_W-1:0]  md0 [2], md1 [2];
  logic              mv0 [2], mv1 [2];
  logic [CP_IDX_W-1:0] ma0, ma1;
  logic [VAL_W-1:0]  tv0 [2], tv1 [2];
  logic [2*VAL_W-1:0] tp0 [2], tp1 [2];
  logic [VAL_W-1:0]  tsum [2];
  logic [VAL_W-1:0]  cres [2];

  assign ty[0] = a_type;
  assign ty[1] = b_type;

  // Lookup positions for the exponential and the curve tables
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ea[l] = EA_W'(u1[l]) * EA_W'(EXP_POINTS - 1);
    end
    ta = TA_W'(p1) * TA_W'(CURVE_POINTS - 1);
  end

  // Stage 1: pick the direct or mirrored position
  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= pos;
      for (int l = 0; l < 2; l++) u1[l] <= is_mirror(ty[l]) ? ONE - pos : pos;
    end
  end

  // Stage 2: first power product, lookup indexes and fractions
  always_ff @(posedge clk) begin
    if (en) begin
      p2  <= p1;
      ti0 <= ta[16 +: CP_IDX_W];
      ti1 <= (ta[16 +: CP_IDX_W] == CP_IDX_W'(CURVE_POINTS - 1)) ?
             ta[16 +: CP_IDX_W] : ta[16 +: CP_IDX_W] + 1'b1;
      tf2 <= ta[15:0];
      for (int l = 0; l < 2; l++) begin
        u2[l]  <= u1[l];
        r2[l]  <= (pow_order(ty[l]) >= 3'd2) ? qmul(u1[l], u1[l]) : u1[l];
        ei0[l] <= ea[l][16 +: EXP_IDX_W];
        ei1[l] <= (ea[l][16 +: EXP_IDX_W] == EXP_IDX_W'(EXP_POINTS - 1)) ?
                  ea[l][16 +: EXP_IDX_W] : ea[l][16 +: EXP_IDX_W] + 1'b1;
        ef2[l] <= ea[l][15:0];
      end
    end
  end

  // Stage 3: second power product, table and ROM reads
  always_ff @(posedge clk) begin
    if (en) begin
      p3  <= p2;
      tf3 <= tf2;
      ma0 <= ti0;
      ma1 <= ti1;
      for (int l = 0; l < 2; l++) begin
        u3[l]  <= u2[l];
        r3[l]  <= (pow_order(ty[l]) >= 3'd3) ? qmul(r2[l], u2[l]) : r2[l];
        et0[l] <= EXP_ROM[ei0[l]];
        et1[l] <= EXP_ROM[ei1[l]];
        ef3[l] <= ef2[l];
      end
    end
  end

  // Curve table memory: one write, two registered reads per table
  always_ff @(posedge clk) begin
    if (en) begin
      if (tab_wr.en) tab_mem[tab_wr.sel][tab_wr.idx] <= tab_wr.val;
      for (int tb = 0; tb < 2; tb++) begin
        md0[tb] <= tab_mem[tb][ti0];
        md1[tb] <= tab_mem[tb][ti1];
      end
    end
  end

  // Entry valid bits and their registered copies; unwritten entries read ramp
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int tb = 0; tb < 2; tb++) begin
        for (int i = 0; i < CURVE_POINTS; i++) tab_vld[tb][i] <= 1'b0;
        mv0[tb] <= 1'b0;
        mv1[tb] <= 1'b0;
      end
    end else if (en) begin
      if (tab_wr.en) tab_vld[tab_wr.sel][tab_wr.idx] <= 1'b1;
      for (int tb = 0; tb < 2; tb++) begin
        mv0[tb] <= tab_vld[tb][ti0];
        mv1[tb] <= tab_vld[tb][ti1];
      end
    end
  end

  always_comb begin
    for (int tb = 0; tb < 2; tb++) begin
      tv0[tb] = mv0[tb] ? md0[tb] : RAMP[ma0];
      tv1[tb] = mv1[tb] ? md1[tb] : RAMP[ma1];
    end
  end

  // Stage 4: third power product, interpolation products
  always_ff @(posedge clk) begin
    if (en) begin
      p4 <= p3;
      for (int l = 0; l < 2; l++) begin
        u4[l]  <= u3[l];
        r4[l]  <= (pow_order(ty[l]) >= 3'd4) ? qmul(r3[l], u3[l]) : r3[l];
        ep0[l] <= (2*VAL_W)'(et0[l]) * (2*VAL_W)'(ONE - {1'b0, ef3[l]});
        ep1[l] <= (2*VAL_W)'(et1[l]) * (2*VAL_W)'(ef3[l]);
      end
      for (int tb = 0; tb < 2; tb++) begin
        tp0[tb] <= (2*VAL_W)'(tv0[tb]) * (2*VAL_W)'(ONE - {1'b0, tf3});
        tp1[tb] <= (2*VAL_W)'(tv1[tb]) * (2*VAL_W)'(tf3);
      end
    end
  end

  // Stage 5: last power product, interpolation sums
  always_ff @(posedge clk) begin
    if (en) begin
      p5 <= p4;
      for (int l = 0; l < 2; l++) begin
        r5[l]   <= (pow_order(ty[l]) >= 3'd5) ? qmul(r4[l], u4[l]) : r4[l];
        esum[l] <= rsum(ep0[l], ep1[l]);
      end
      for (int tb = 0; tb < 2; tb++) tsum[tb] <= rsum(tp0[tb], tp1[tb]);
    end
  end

  // Stage 6: select each curve's result
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        case (ty[l])
          CRV_LINEAR:  cres[l] <= p5;
          CRV_EXP:     cres[l] <= esum[l];
          CRV_EXP_MIR: cres[l] <= ONE - esum[l];
          CRV_POW5, CRV_POW4, CRV_POW3, CRV_POW2: cres[l] <= r5[l];
          CRV_MPOW2, CRV_MPOW3, CRV_MPOW4, CRV_MPOW5: cres[l] <= ONE - r5[l];
          CRV_PH90:    cres[l] <= {1'b0, p5[15:0] + PH_90};
          CRV_PH180:   cres[l] <= {1'b0, p5[15:0] + PH_180};
          CRV_PH270:   cres[l] <= {1'b0, p5[15:0] + PH_270};
          CRV_TAB1:    cres[l] <= tsum[0];
          CRV_TAB2:    cres[l] <= tsum[1];
          default:     cres[l] <= p5;
        endcase
      end
    end
  end

  assign curve_a = cres[0];
  assign curve_b = cres[1];

endmodule

// File: design/mrcs_back.sv
// Back end: position divide, quantize, curve evaluation, morph blend, range
// map and the result queue. Uses mrcs_pkg, mrcs_div and mrcs_curves.
module mrcs_back import mrcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  mid_item_t        mid_head,
  input  logic             mid_empty,
  output logic             mid_pop,
  output logic             empty,
  input  logic             pop,
  output logic [VAL_W-1:0] shaped_value
);

  localparam int QP_W = VAL_W + STEP_W;

  logic              en;
  logic              sd_vld [1:BACK_LAT];
  mid_item_t         sd     [1:BACK_LAT];
  logic [VAL_W-1:0]  pos_raw, pos_fin;
  logic [STEP_W-1:0] s_lim, s_m1;
  logic [QP_W-1:0]   qprod;
  logic [VAL_W-1:0]  qq;
  logic [VAL_W-1:0]  qnum, qden;
  tab_wr_t           tab_wr;
  logic [VAL_W-1:0]  ca, cb, m, cbl, rl, rh, res;
  logic [2*VAL_W-1:0] bp0, bp1, rp0, rp1;
  logic [VAL_W-1:0]  out_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] owptr, orptr;
  logic [OUT_PTR_W:0]   ocount;
  logic              opush, opop;

  // Whole pipeline advances while the result queue has room
  assign en      = (ocount != (OUT_PTR_W+1)'(OUT_DEPTH));
  assign mid_pop = en && !mid_empty;

  // Sideband line: word kind and table fields follow the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= BACK_LAT; j++) sd_vld[j] <= 1'b0;
    end else if (en) begin
      sd_vld[1] <= mid_pop;
      for (int j = 2; j <= BACK_LAT; j++) sd_vld[j] <= sd_vld[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= mid_head;
      for (int j = 2; j <= BACK_LAT; j++) sd[j] <= sd[j-1];
    end
  end

  // Window position
  mrcs_div u_div_pos (
    .clk (clk),
    .en  (en),
    .num (mid_head.num),
    .den (mid_head.den),
    .quo (pos_raw)
  );

  // Quantize: level index, then a second divide by levels less one; under two steps, pass through
  always_comb begin
    s_lim = (cfg.steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : cfg.steps;
    s_m1  = s_lim - 1'b1;
    qprod = QP_W'(pos_raw) * QP_W'(s_lim);
    qq    = VAL_W'(qprod[QP_W-1:16]);
    if (qq > VAL_W'(s_m1)) qq = VAL_W'(s_m1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_lim >= STEP_W'(2)) begin
        qnum <= qq;
        qden <= VAL_W'(s_m1);
      end else begin
        qnum <= pos_raw;
        qden <= ONE;
      end
    end
  end

  mrcs_div u_div_qnt (
    .clk (clk),
    .en  (en),
    .num (qnum),
    .den (qden),
    .quo (pos_fin)
  );

  // Table writes land where sample reads are issued, keeping word order
  always_comb begin
    tab_wr.en  = sd_vld[TAB_WR_AT] && sd[TAB_WR_AT].wr &&
                 ({1'b0, sd[TAB_WR_AT].idx} < (CP_IDX_W+1)'(CURVE_POINTS));
    tab_wr.sel = sd[TAB_WR_AT].sel;
    tab_wr.idx = sd[TAB_WR_AT].idx;
    tab_wr.val = sd[TAB_WR_AT].val;
  end

  mrcs_curves u_curves (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_type  (cfg.a_type),
    .b_type  (cfg.b_type),
    .pos     (pos_fin),
    .tab_wr  (tab_wr),
    .curve_a (ca),
    .curve_b (cb)
  );

  assign m  = sat_one(cfg.morph);
  assign rl = sat_one(cfg.rng_lo);
  assign rh = sat_one(cfg.rng_hi);

  // Morph blend, then range map
  always_ff @(posedge clk) begin
    if (en) begin
      bp0 <= (2*VAL_W)'(ca) * (2*VAL_W)'(ONE - m);
      bp1 <= (2*VAL_W)'(cb) * (2*VAL_W)'(m);
      cbl <= rsum(bp0, bp1);
      rp0 <= (2*VAL_W)'(rl) * (2*VAL_W)'(ONE - cbl);
      rp1 <= (2*VAL_W)'(rh) * (2*VAL_W)'(cbl);
      res <= rsum(rp0, rp1);
    end
  end

  // Result queue
  assign opush        = en && sd_vld[BACK_LAT] && !sd[BACK_LAT].wr;
  assign empty        = (ocount == '0);
  assign opop         = pop && !empty;
  assign shaped_value = out_mem[orptr];

  always_ff @(posedge clk) begin
    if (opush) out_mem[owptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
    end else begin
      if (opush) owptr <= owptr + 1'b1;
      if (opop)  orptr <= orptr + 1'b1;
      ocount <= ocount + (OUT_PTR_W+1)'(opush) - (OUT_PTR_W+1)'(opop);
    end
  end

  // A stall freezes the sideband line
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(sd_vld[BACK_LAT]) && $stable(sd_vld[1]))
    else $error("sideband moved during stall");

  // A popped word enters the line
  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    mid_pop |=> sd_vld[1])
    else $error("popped word lost");

  // Never overfill the result queue
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    opush && !opop |-> ocount < (OUT_PTR_W+1)'(OUT_DEPTH))
    else $error("result queue overfilled");

endmodule

// File: design/morphing_response_curve_shaper.sv
// Top level of the morphing response curve shaper: configuration registers,
// front end and back end. Uses mrcs_pkg, mrcs_front and mrcs_back.
//
// The block takes one word per cycle on the push side while full is low,
// and gives one result per sample word on the pop side; table-write words
// give no result and are applied in word order, so samples pushed after a
// write see the new entry. A sample passes through the two bit-per-stage
// dividers (window position and quantize), then curve evaluation and the
// blend and range multipliers. The whole back end pauses only when its
// four-entry result queue is full; the front queue holds four words. Write
// configuration only while the block is idle.
module morphing_response_curve_shaper import mrcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                req_type,
  input  logic [VAL_W-1:0]    sample_value,
  input  logic                table_select,
  input  logic [CP_IDX_W-1:0] table_index,
  input  logic [VAL_W-1:0]    table_value,
  output logic                empty,
  input  logic                pop,
  output logic [VAL_W-1:0]    shaped_value,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [VAL_W-1:0]    cfg_data
);

  cfg_t      cfg;
  mid_item_t mid_head;
  logic      mid_empty, mid_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_type <= CRV_LINEAR;
      cfg.b_type <= CRV_LINEAR;
      cfg.morph  <= '0;
      cfg.win_lo <= '0;
      cfg.win_hi <= ONE;
      cfg.rng_lo <= '0;
      cfg.rng_hi <= ONE;
      cfg.steps  <= '0;
    end else if (cfg_we) begin
      case (reg_idx_e'(cfg_index))
        REG_CURVE_A: cfg.a_type <= curve_e'(cfg_data[3:0]);
        REG_CURVE_B: cfg.b_type <= curve_e'(cfg_data[3:0]);
        REG_MORPH:   cfg.morph  <= cfg_data;
        REG_WIN_LO:  cfg.win_lo <= cfg_data;
        REG_WIN_HI:  cfg.win_hi <= cfg_data;
        REG_RNG_LO:  cfg.rng_lo <= cfg_data;
        REG_RNG_HI:  cfg.rng_hi <= cfg_data;
        REG_STEPS:   cfg.steps  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  mrcs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .sample_value (sample_value),
    .table_select (table_select),
    .table_index  (table_index),
    .table_value  (table_value),
    .mid_pop      (mid_pop),
    .mid_head     (mid_head),
    .mid_empty    (mid_empty)
  );

  mrcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .mid_head     (mid_head),
    .mid_empty    (mid_empty),
    .mid_pop      (mid_pop),
    .empty        (empty),
    .pop          (pop),
    .shaped_value (shaped_value)
  );

endmodule
